>>> rtl/i4lp_pkg.sv
package i4lp_pkg;

    localparam logic [3:0] MODE_VERT   = 4'd0;
    localparam logic [3:0] MODE_HOR    = 4'd1;
    localparam logic [3:0] MODE_DC     = 4'd2;
    localparam logic [3:0] MODE_DDL    = 4'd3;
    localparam logic [3:0] MODE_DDR    = 4'd4;
    localparam logic [3:0] MODE_VR     = 4'd5;
    localparam logic [3:0] MODE_HD     = 4'd6;
    localparam logic [3:0] MODE_VL     = 4'd7;
    localparam logic [3:0] MODE_HU     = 4'd8;
    localparam logic [3:0] MODE_DCLEFT = 4'd9;
    localparam logic [3:0] MODE_DCTOP  = 4'd10;
    localparam logic [3:0] MODE_DC128  = 4'd11;

    localparam logic [31:0] FLAT_128  = 32'h8080_8080;
    localparam logic [1:0]  LAST_ROW  = 2'd3;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  block_col;
        logic [1:0]  block_row;
        logic [15:0] topright_mask;
        logic [7:0]  corner_pixel;
        logic [31:0] top_pixels;
        logic [31:0] topright_pixels;
        logic [31:0] left_pixels;
    } t_in_item;

    typedef struct packed {
        logic [31:0] row_pixels;
        logic [1:0]  row_number;
        logic        last;
        logic        mode_error;
    } t_out_item;

    typedef struct packed {
        logic [3:0][31:0] rows;
        logic             err;
    } t_blk;

    function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    function automatic logic [7:0] filt3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [9:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
        return s[9:2];
    endfunction

    function automatic logic [31:0] splat(input logic [7:0] v);
        return {v, v, v, v};
    endfunction

endpackage

>>> rtl/i4lp_pred.sv
module i4lp_pred (
    input  i4lp_pkg::t_in_item i_req,
    output i4lp_pkg::t_blk     o_blk
);
    import i4lp_pkg::*;

    logic [7:0] t [8];
    logic [7:0] l [4];
    logic [7:0] p [10];
    logic [7:0] m;
    logic [3:0] z;
    logic       tr_avail;
    logic [10:0] sum_all;
    logic [9:0]  sum_l;
    logic [9:0]  sum_t;

    assign z        = {i_req.block_row[1], i_req.block_col[1],
                       i_req.block_row[0], i_req.block_col[0]};
    assign tr_avail = i_req.topright_mask[4'd15 - z];
    assign m        = i_req.corner_pixel;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            t[k] = i_req.top_pixels[8*k +: 8];
            l[k] = i_req.left_pixels[8*k +: 8];
            if (!tr_avail && (i_req.op == MODE_DDL || i_req.op == MODE_VL)) begin
                t[4+k] = i_req.top_pixels[31:24];
            end else begin
                t[4+k] = i_req.topright_pixels[8*k +: 8];
            end
        end
    end

    assign sum_t   = {2'b00, t[0]} + {2'b00, t[1]} + {2'b00, t[2]} + {2'b00, t[3]};
    assign sum_l   = {2'b00, l[0]} + {2'b00, l[1]} + {2'b00, l[2]} + {2'b00, l[3]};
    assign sum_all = {1'b0, sum_t} + {1'b0, sum_l} + 11'd4;

    always_comb begin
        logic [9:0] dc4;
        dc4 = 10'd0;
        for (int k = 0; k < 10; k++) begin
            p[k] = 8'd0;
        end
        o_blk.err  = 1'b0;
        o_blk.rows = '0;
        unique case (i_req.op)
            MODE_VERT: begin
                for (int k = 0; k < 4; k++) o_blk.rows[k] = {t[3], t[2], t[1], t[0]};
            end
            MODE_HOR: begin
                for (int k = 0; k < 4; k++) o_blk.rows[k] = splat(l[k]);
            end
            MODE_DC: begin
                for (int k = 0; k < 4; k++) o_blk.rows[k] = splat(sum_all[10:3]);
            end
            MODE_DDL: begin
                for (int k = 0; k < 6; k++) p[k] = filt3(t[k], t[k+1], t[k+2]);
                p[6] = filt3(t[6], t[7], t[7]);
                for (int k = 0; k < 4; k++) begin
                    o_blk.rows[k] = {p[k+3], p[k+2], p[k+1], p[k]};
                end
            end
            MODE_DDR: begin
                p[0] = filt3(l[1], l[2], l[3]);
                p[1] = filt3(l[0], l[1], l[2]);
                p[2] = filt3(m, l[0], l[1]);
                p[3] = filt3(t[0], m, l[0]);
                p[4] = filt3(t[1], t[0], m);
                p[5] = filt3(t[2], t[1], t[0]);
                p[6] = filt3(t[3], t[2], t[1]);
                for (int k = 0; k < 4; k++) begin
                    o_blk.rows[k] = {p[6-k], p[5-k], p[4-k], p[3-k]};
                end
            end
            MODE_VR: begin
                p[0] = filt3(l[1], l[0], m);
                p[1] = avg2(m, t[0]);
                p[2] = avg2(t[0], t[1]);
                p[3] = avg2(t[1], t[2]);
                p[4] = avg2(t[2], t[3]);
                p[5] = filt3(l[2], l[1], l[0]);
                p[6] = filt3(l[0], m, t[0]);
                p[7] = filt3(m, t[0], t[1]);
                p[8] = filt3(t[0], t[1], t[2]);
                p[9] = filt3(t[1], t[2], t[3]);
                o_blk.rows[0] = {p[4], p[3], p[2], p[1]};
                o_blk.rows[1] = {p[9], p[8], p[7], p[6]};
                o_blk.rows[2] = {p[3], p[2], p[1], p[0]};
                o_blk.rows[3] = {p[8], p[7], p[6], p[5]};
            end
            MODE_HD: begin
                p[0] = avg2(l[2], l[3]);
                p[1] = filt3(l[1], l[2], l[3]);
                p[2] = avg2(l[1], l[2]);
                p[3] = filt3(l[0], l[1], l[2]);
                p[4] = avg2(l[0], l[1]);
                p[5] = filt3(m, l[0], l[1]);
                p[6] = avg2(m, l[0]);
                p[7] = filt3(t[0], m, l[0]);
                p[8] = filt3(t[1], t[0], m);
                p[9] = filt3(t[2], t[1], t[0]);
                for (int k = 0; k < 4; k++) begin
                    o_blk.rows[k] = {p[9-2*k], p[8-2*k], p[7-2*k], p[6-2*k]};
                end
            end
            MODE_VL: begin
                for (int k = 0; k < 5; k++) begin
                    p[k]   = avg2(t[k], t[k+1]);
                    p[5+k] = filt3(t[k], t[k+1], t[k+2]);
                end
                o_blk.rows[0] = {p[3], p[2], p[1], p[0]};
                o_blk.rows[1] = {p[8], p[7], p[6], p[5]};
                o_blk.rows[2] = {p[4], p[3], p[2], p[1]};
                o_blk.rows[3] = {p[9], p[8], p[7], p[6]};
            end
            MODE_HU: begin
                p[0] = avg2(l[0], l[1]);
                p[1] = filt3(l[0], l[1], l[2]);
                p[2] = avg2(l[1], l[2]);
                p[3] = filt3(l[1], l[2], l[3]);
                p[4] = avg2(l[2], l[3]);
                p[5] = filt3(l[2], l[3], l[3]);
                for (int k = 6; k < 10; k++) p[k] = l[3];
                for (int k = 0; k < 4; k++) begin
                    o_blk.rows[k] = {p[2*k+3], p[2*k+2], p[2*k+1], p[2*k]};
                end
            end
            MODE_DCLEFT: begin
                dc4 = sum_l + 10'd2;
                for (int k = 0; k < 4; k++) o_blk.rows[k] = splat(dc4[9:2]);
            end
            MODE_DCTOP: begin
                dc4 = sum_t + 10'd2;
                for (int k = 0; k < 4; k++) o_blk.rows[k] = splat(dc4[9:2]);
            end
            MODE_DC128: begin
                for (int k = 0; k < 4; k++) o_blk.rows[k] = FLAT_128;
            end
            default: begin
                o_blk.err = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/intra4x4_luma_predictor_core.sv
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_stall    | i_in  (t_in_item)
// out     | output    | o_out_valid / i_out_stall  | o_out (t_out_item, one row)
//
// One block request is registered, predicted in a single combinational pass into
// the row buffer, and drained one row per cycle unless stalled (a single error row
// for an illegal mode). The row buffer drain sets the rate; the request register
// refills while the previous block drains, so blocks stream back to back.
// Synchronous active-low reset empties both stages. A stall holds the current row.
module intra4x4_luma_predictor_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  i4lp_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output i4lp_pkg::t_out_item  o_out
);
    import i4lp_pkg::*;

    t_in_item   r_req;
    logic       r_req_vld;
    t_blk       r_blk;
    logic       r_blk_vld;
    logic [1:0] r_row;
    logic [1:0] n_row;
    t_blk       pred_blk;
    logic       out_take;
    logic       out_last;
    logic       blk_load;
    logic       in_take;

    i4lp_pred u_pred (
        .i_req (r_req),
        .o_blk (pred_blk)
    );

    assign out_last = r_blk.err || (r_row == LAST_ROW);
    assign out_take = r_blk_vld && !i_out_stall;
    assign blk_load = r_req_vld && (!r_blk_vld || (out_take && out_last));
    assign in_take  = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_req_vld && !blk_load;
    assign o_out_valid = r_blk_vld;

    always_comb begin
        o_out.row_pixels = r_blk.rows[r_row];
        o_out.row_number = r_row;
        o_out.last       = out_last;
        o_out.mode_error = r_blk.err;
        if (r_blk.err) begin
            o_out.row_pixels = '0;
        end
    end

    always_comb begin
        n_row = r_row;
        if (blk_load) begin
            n_row = 2'd0;
        end else if (out_take) begin
            n_row = r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_blk_vld <= 1'b0;
            r_row     <= 2'd0;
        end else begin
            r_row <= n_row;
            if (in_take) begin
                r_req_vld <= 1'b1;
            end else if (blk_load) begin
                r_req_vld <= 1'b0;
            end
            if (blk_load) begin
                r_blk_vld <= 1'b1;
            end else if (out_take && out_last) begin
                r_blk_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= i_in;
        end
        if (blk_load) begin
            r_blk <= pred_blk;
        end
    end

endmodule

>>> tb/sv/intra4x4_luma_predictor_core_tb.sv
module intra4x4_luma_predictor_core_tb;
    import i4lp_pkg::*;

    localparam logic [3:0] MODE_ILLEGAL_LO = 4'd12;
    localparam logic [3:0] MODE_ILLEGAL_HI = 4'd15;
    localparam int         HOLD_CYCLES     = 80;
    localparam int         IDLE_LIMIT      = 1000;
    localparam int         DRAIN_CYCLES    = 10;

    typedef struct {
        t_in_item    req;
        bit          typed;
        bit          typed_err;
        logic [31:0] typed_pix;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    t_out_item pred_rows[$];
    t_dir_row  dir_tab[$];
    int        errors    = 0;
    int        n_blocks  = 0;
    int        n_illegal = 0;
    int        n_rows    = 0;
    int        idle_cnt  = 0;
    bit        tx_idle   = 1'b1;
    bit        rx_idle   = 1'b1;
    bit        hold_req  = 1'b0;
    int        hold_left = 0;
    int        rx_burst  = 0;

    intra4x4_luma_predictor_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] mean2(input int a, input int b);
        return 8'((a + b + 1) >> 1);
    endfunction

    function automatic logic [7:0] tap3(input int a, input int b, input int c);
        return 8'((a + 2 * b + c + 2) >> 2);
    endfunction

    function automatic logic [31:0] row_of(input int a, input int b, input int c, input int d);
        return {8'(d), 8'(c), 8'(b), 8'(a)};
    endfunction

    function automatic void predict_block(input t_in_item req);
        int          t[8];
        int          l[4];
        int          p[10];
        int          m;
        int          z;
        int          dc;
        logic [31:0] r[4];
        t_out_item   res;
        m = req.corner_pixel;
        for (int k = 0; k < 4; k++) begin
            t[k]     = req.top_pixels[8*k +: 8];
            t[4 + k] = req.topright_pixels[8*k +: 8];
            l[k]     = req.left_pixels[8*k +: 8];
        end
        z = {req.block_row[1], req.block_col[1], req.block_row[0], req.block_col[0]};
        if (!req.topright_mask[15 - z] && (req.op == MODE_DDL || req.op == MODE_VL)) begin
            for (int k = 4; k < 8; k++) t[k] = t[3];
        end
        case (req.op)
            MODE_VERT: begin
                for (int k = 0; k < 4; k++) r[k] = row_of(t[0], t[1], t[2], t[3]);
            end
            MODE_HOR: begin
                for (int k = 0; k < 4; k++) r[k] = {4{8'(l[k])}};
            end
            MODE_DC: begin
                dc = (t[0] + t[1] + t[2] + t[3] + l[0] + l[1] + l[2] + l[3] + 4) >> 3;
                for (int k = 0; k < 4; k++) r[k] = {4{8'(dc)}};
            end
            MODE_DDL: begin
                for (int k = 0; k < 6; k++) p[k] = tap3(t[k], t[k + 1], t[k + 2]);
                p[6] = tap3(t[6], t[7], t[7]);
                for (int k = 0; k < 4; k++) r[k] = row_of(p[k], p[k + 1], p[k + 2], p[k + 3]);
            end
            MODE_DDR: begin
                p[0] = tap3(l[1], l[2], l[3]);
                p[1] = tap3(l[0], l[1], l[2]);
                p[2] = tap3(m, l[0], l[1]);
                p[3] = tap3(t[0], m, l[0]);
                p[4] = tap3(t[1], t[0], m);
                p[5] = tap3(t[2], t[1], t[0]);
                p[6] = tap3(t[3], t[2], t[1]);
                for (int k = 0; k < 4; k++) r[k] = row_of(p[3 - k], p[4 - k], p[5 - k], p[6 - k]);
            end
            MODE_VR: begin
                p[0] = tap3(l[1], l[0], m);
                p[1] = mean2(m, t[0]);
                p[2] = mean2(t[0], t[1]);
                p[3] = mean2(t[1], t[2]);
                p[4] = mean2(t[2], t[3]);
                p[5] = tap3(l[2], l[1], l[0]);
                p[6] = tap3(l[0], m, t[0]);
                p[7] = tap3(m, t[0], t[1]);
                p[8] = tap3(t[0], t[1], t[2]);
                p[9] = tap3(t[1], t[2], t[3]);
                r[0] = row_of(p[1], p[2], p[3], p[4]);
                r[1] = row_of(p[6], p[7], p[8], p[9]);
                r[2] = row_of(p[0], p[1], p[2], p[3]);
                r[3] = row_of(p[5], p[6], p[7], p[8]);
            end
            MODE_HD: begin
                p[0] = mean2(l[2], l[3]);
                p[1] = tap3(l[1], l[2], l[3]);
                p[2] = mean2(l[1], l[2]);
                p[3] = tap3(l[0], l[1], l[2]);
                p[4] = mean2(l[0], l[1]);
                p[5] = tap3(m, l[0], l[1]);
                p[6] = mean2(m, l[0]);
                p[7] = tap3(t[0], m, l[0]);
                p[8] = tap3(t[1], t[0], m);
                p[9] = tap3(t[2], t[1], t[0]);
                for (int k = 0; k < 4; k++) begin
                    r[k] = row_of(p[6 - 2*k], p[7 - 2*k], p[8 - 2*k], p[9 - 2*k]);
                end
            end
            MODE_VL: begin
                for (int k = 0; k < 5; k++) begin
                    p[k]     = mean2(t[k], t[k + 1]);
                    p[5 + k] = tap3(t[k], t[k + 1], t[k + 2]);
                end
                r[0] = row_of(p[0], p[1], p[2], p[3]);
                r[1] = row_of(p[5], p[6], p[7], p[8]);
                r[2] = row_of(p[1], p[2], p[3], p[4]);
                r[3] = row_of(p[6], p[7], p[8], p[9]);
            end
            MODE_HU: begin
                p[0] = mean2(l[0], l[1]);
                p[1] = tap3(l[0], l[1], l[2]);
                p[2] = mean2(l[1], l[2]);
                p[3] = tap3(l[1], l[2], l[3]);
                p[4] = mean2(l[2], l[3]);
                p[5] = tap3(l[2], l[3], l[3]);
                for (int k = 6; k < 10; k++) p[k] = l[3];
                for (int k = 0; k < 4; k++) begin
                    r[k] = row_of(p[2*k], p[2*k + 1], p[2*k + 2], p[2*k + 3]);
                end
            end
            MODE_DCLEFT: begin
                dc = (l[0] + l[1] + l[2] + l[3] + 2) >> 2;
                for (int k = 0; k < 4; k++) r[k] = {4{8'(dc)}};
            end
            MODE_DCTOP: begin
                dc = (t[0] + t[1] + t[2] + t[3] + 2) >> 2;
                for (int k = 0; k < 4; k++) r[k] = {4{8'(dc)}};
            end
            MODE_DC128: begin
                for (int k = 0; k < 4; k++) r[k] = FLAT_128;
            end
            default: begin
                res = '{32'd0, 2'd0, 1'b1, 1'b1};
                pred_rows.push_back(res);
                return;
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            res = '{r[k], 2'(k), k == 3, 1'b0};
            pred_rows.push_back(res);
        end
    endfunction

    function automatic t_in_item mk_req(input logic [3:0] op, input logic [1:0] col,
                                        input logic [1:0] row, input logic [15:0] mask,
                                        input logic [7:0] m, input logic [31:0] top,
                                        input logic [31:0] tr, input logic [31:0] lf);
        t_in_item q;
        q = '{op, col, row, mask, m, top, tr, lf};
        return q;
    endfunction

    function automatic t_in_item rand_req();
        t_in_item q;
        int       pick;
        q.op = 4'($urandom_range(MODE_VERT, MODE_DC128));
        if ($urandom_range(0, 15) == 0) q.op = 4'($urandom_range(MODE_ILLEGAL_LO, MODE_ILLEGAL_HI));
        q.block_col       = 2'($urandom);
        q.block_row       = 2'($urandom);
        q.topright_mask   = 16'($urandom);
        q.corner_pixel    = 8'($urandom);
        q.top_pixels      = $urandom;
        q.topright_pixels = $urandom;
        q.left_pixels     = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            q.corner_pixel = '0; q.top_pixels = '0; q.topright_pixels = '0; q.left_pixels = '0;
        end else if (pick == 1) begin
            q.corner_pixel = '1; q.top_pixels = '1; q.topright_pixels = '1; q.left_pixels = '1;
        end else if (pick == 2) begin
            q.topright_mask = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        end
        return q;
    endfunction

    task automatic send_block(input t_in_item req, input bit typed, input bit typed_err,
                              input logic [31:0] typed_pix);
        int        gap;
        t_out_item res;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in       = req;
        do @(posedge i_clk); while (o_in_stall);
        if (!typed) begin
            predict_block(req);
        end else if (typed_err) begin
            res = '{32'd0, 2'd0, 1'b1, 1'b1};
            pred_rows.push_back(res);
        end else begin
            for (int k = 0; k < 4; k++) begin
                res = '{typed_pix, 2'(k), k == 3, 1'b0};
                pred_rows.push_back(res);
            end
        end
        n_blocks++;
        if (req.op > MODE_DC128) n_illegal++;
    endtask

    // output side stall: random bursts, or one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else if (hold_req) begin
            hold_req    = 1'b0;
            hold_left   = HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else if (rx_burst != 0) begin
            rx_burst--;
            i_out_stall = 1'b1;
        end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rx_burst    = $urandom_range(0, 9);
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_row;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_rows++;
            if (pred_rows.size() == 0) begin
                $display("%0t: unexpected row result, expected none, got %h", $time, o_out);
                errors++;
            end else begin
                exp_row = pred_rows.pop_front();
                if (o_out.row_pixels !== exp_row.row_pixels) begin
                    $display("%0t: row_pixels expected %h got %h", $time,
                             exp_row.row_pixels, o_out.row_pixels);
                    errors++;
                end
                if (o_out.row_number !== exp_row.row_number) begin
                    $display("%0t: row_number expected %0d got %0d", $time,
                             exp_row.row_number, o_out.row_number);
                    errors++;
                end
                if (o_out.last !== exp_row.last) begin
                    $display("%0t: last expected %b got %b", $time, exp_row.last, o_out.last);
                    errors++;
                end
                if (o_out.mode_error !== exp_row.mode_error) begin
                    $display("%0t: mode_error expected %b got %b", $time,
                             exp_row.mode_error, o_out.mode_error);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cnt = 0;
        end else if (i_rst_n) begin
            idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d rows outstanding", $time,
                         IDLE_LIMIT, pred_rows.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        dir_tab.push_back('{mk_req(MODE_DC128, 2'd0, 2'd0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0),
                            1'b1, 1'b0, FLAT_128});
        dir_tab.push_back('{mk_req(MODE_DC128, 2'd3, 2'd3, 16'hFFFF, 8'hFF, '1, '1, '1),
                            1'b1, 1'b0, FLAT_128});
        dir_tab.push_back('{mk_req(MODE_ILLEGAL_LO, 2'd0, 2'd0, 16'h0000, 8'h00, 32'h0, 32'h0,
                                   32'h0), 1'b1, 1'b1, 32'h0});
        dir_tab.push_back('{mk_req(MODE_ILLEGAL_HI, 2'd3, 2'd3, 16'hFFFF, 8'hFF, '1, '1, '1),
                            1'b1, 1'b1, 32'h0});
        dir_tab.push_back('{mk_req(MODE_VERT, 2'd1, 2'd2, 16'($urandom), 8'h00, '1, $urandom,
                                   $urandom), 1'b1, 1'b0, 32'hFFFF_FFFF});
        dir_tab.push_back('{mk_req(MODE_VERT, 2'd2, 2'd1, 16'($urandom), 8'hFF, 32'h0, $urandom,
                                   $urandom), 1'b1, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_HOR, 2'd0, 2'd3, 16'($urandom), 8'hFF, $urandom,
                                   $urandom, 32'h0), 1'b1, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_HOR, 2'd3, 2'd0, 16'($urandom), 8'h00, $urandom,
                                   $urandom, '1), 1'b1, 1'b0, 32'hFFFF_FFFF});
        dir_tab.push_back('{mk_req(MODE_DC, 2'd1, 2'd1, 16'h0000, 8'h00, '1, 32'h0, '1),
                            1'b1, 1'b0, 32'hFFFF_FFFF});
        dir_tab.push_back('{mk_req(MODE_DC, 2'd2, 2'd2, 16'hFFFF, 8'hFF, 32'h0, '1, 32'h0),
                            1'b1, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_DCLEFT, 2'd0, 2'd1, 16'($urandom), 8'h00, 32'h0, 32'h0,
                                   '1), 1'b1, 1'b0, 32'hFFFF_FFFF});
        dir_tab.push_back('{mk_req(MODE_DCTOP, 2'd1, 2'd0, 16'($urandom), 8'hFF, 32'h0, '1, '1),
                            1'b1, 1'b0, 32'h0});
        // top-right unavailable: the last top pixel is replicated
        dir_tab.push_back('{mk_req(MODE_DDL, 2'd3, 2'd3, 16'h0000, 8'($urandom), $urandom, '1,
                                   $urandom), 1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_DDL, 2'd0, 2'd0, 16'hFFFF, 8'($urandom), $urandom,
                                   $urandom, $urandom), 1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_VL, 2'd1, 2'd2, 16'h0000, 8'($urandom), $urandom, '1,
                                   $urandom), 1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_VL, 2'd2, 2'd1, 16'hFFFF, 8'($urandom), $urandom,
                                   $urandom, $urandom), 1'b0, 1'b0, 32'h0});
        // only the bit of this block set, then only this bit clear
        dir_tab.push_back('{mk_req(MODE_DDL, 2'd1, 2'd1, 16'h1000, 8'($urandom), $urandom,
                                   $urandom, $urandom), 1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_VL, 2'd1, 2'd1, 16'hEFFF, 8'($urandom), $urandom,
                                   $urandom, $urandom), 1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_DDR, 2'd3, 2'd0, 16'($urandom), 8'hFF, '1, '1, '1),
                            1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_VR, 2'd0, 2'd3, 16'($urandom), 8'h00, '1, $urandom, '1),
                            1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_HD, 2'd2, 2'd3, 16'($urandom), 8'($urandom), $urandom,
                                   $urandom, $urandom), 1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_HU, 2'd3, 2'd2, 16'($urandom), 8'($urandom), $urandom,
                                   $urandom, '1), 1'b0, 1'b0, 32'h0});
        dir_tab.push_back('{mk_req(MODE_HU, 2'd2, 2'd0, 16'($urandom), 8'($urandom), $urandom,
                                   $urandom, $urandom), 1'b0, 1'b0, 32'h0});

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            send_block(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].typed_err,
                       dir_tab[i].typed_pix);
        end

        repeat (150) send_block(rand_req(), 1'b0, 1'b0, '0);

        // long output hold-off while requests keep coming back to back
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (24) send_block(rand_req(), 1'b0, 1'b0, '0);
        tx_idle = 1'b1;

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pred_rows.size() != 0) @(posedge i_clk);

        repeat (180) send_block(rand_req(), 1'b0, 1'b0, '0);

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (50) send_block(rand_req(), 1'b0, 1'b0, '0);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pred_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d block requests (%0d with illegal modes), checked %0d row results.",
                 n_blocks, n_illegal, n_rows);
        $display("Covered all prediction modes, top-right availability, long output hold-off.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
